// File: design/lcrr_pkg.sv
// lcrr_pkg: field widths shared by the lane conflict selector and its channel interfaces.
// No dependencies.
package lcrr_pkg;

  localparam int EVAL_COUNT_W = 3;   // evaluation count field
  localparam int FLAG_W       = 4;   // eligible / evaluated flag fields
  localparam int DEST_W       = 16;  // one lane destination mask field
  localparam int DEST_FIELDS  = 4;   // destination mask fields per beat
  localparam int GRANT_W      = 8;   // granted_mask field
  localparam int CURSOR_W     = 5;   // next_cursor field and stored cursor

endpackage

// File: design/lcrr_in_if.sv
// lcrr_in_if / lcrr_out_if: valid/ready channels of the lane conflict selector.
// Depends on lcrr_pkg.
interface lcrr_in_if import lcrr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [EVAL_COUNT_W-1:0] eval_count;
  logic [FLAG_W-1:0]       eligible_bits;
  logic [FLAG_W-1:0]       evaluated_bits;
  logic [DEST_W-1:0]       lane_dest_a;
  logic [DEST_W-1:0]       lane_dest_b;
  logic [DEST_W-1:0]       lane_dest_c;
  logic [DEST_W-1:0]       lane_dest_d;
  logic                    last_requester;

  modport source (
    output valid, eval_count, eligible_bits, evaluated_bits,
    output lane_dest_a, lane_dest_b, lane_dest_c, lane_dest_d, last_requester,
    input  ready
  );
  modport sink (
    input  valid, eval_count, eligible_bits, evaluated_bits,
    input  lane_dest_a, lane_dest_b, lane_dest_c, lane_dest_d, last_requester,
    output ready
  );
endinterface

interface lcrr_out_if import lcrr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [GRANT_W-1:0]  granted_mask;
  logic [CURSOR_W-1:0] next_cursor;
  logic                found_eligible;

  modport source (
    output valid, granted_mask, next_cursor, found_eligible,
    input  ready
  );
  modport sink (
    input  valid, granted_mask, next_cursor, found_eligible,
    output ready
  );
endinterface

// File: design/lane_conflict_round_robin_selector.sv
// Lane conflict round-robin selector: request store, position scan and grant walk.
// Depends on lcrr_pkg and the channel interfaces in lcrr_in_if.sv.
//
// Each input beat loads one requester into a register store (one beat per cycle while idle).
// The beat flagged last_requester triggers a selection round run by a small sequencer over a
// single store read port: LOCATE walks requesters from 0 to find where the stored cursor
// falls, SCAN visits one flattened (requester, evaluation) position per cycle round-robin
// until an eligible one is found, GRANT (only if one was found) visits every loaded
// requester once starting at that position's requester, and DONE hands the result to the
// output register, waiting while the previous result is still there. The block takes no
// beat until the round is over. Results sit in an output register, so loading of the next
// round proceeds while a result waits to be taken. Requesters past MAX_REQUESTERS are
// dropped.
module lane_conflict_round_robin_selector
  import lcrr_pkg::*;
#(
  parameter int MAX_REQUESTERS      = 8,
  parameter int MAX_EVALS           = 4,
  parameter int DESTS_PER_REQUESTER = 4,
  parameter int LANE_COUNT          = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lcrr_in_if.sink   in_i,
  lcrr_out_if.source out_o
);

  // Derived sizes
  localparam int ReqW    = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
  localparam int CntW    = $clog2(MAX_REQUESTERS + 1);
  localparam int EvW     = (MAX_EVALS > 1) ? $clog2(MAX_EVALS) : 1;
  localparam int EvCntW  = $clog2(MAX_EVALS + 1);
  localparam int PosMaxW = $clog2(MAX_REQUESTERS * MAX_EVALS + 1);
  localparam int PW      = (PosMaxW > CURSOR_W) ? PosMaxW : CURSOR_W;
  localparam int LaneW   = (LANE_COUNT < DEST_W) ? LANE_COUNT : DEST_W;
  localparam int NDest   = (DESTS_PER_REQUESTER < DEST_FIELDS) ? DESTS_PER_REQUESTER
                                                              : DEST_FIELDS;
  localparam int GW      = (MAX_REQUESTERS > GRANT_W) ? MAX_REQUESTERS : GRANT_W;

  typedef struct packed {
    logic [EvCntW-1:0]          evals;
    logic [FLAG_W-1:0]          elig;
    logic [FLAG_W-1:0]          evald;
    logic [NDest-1:0][LaneW-1:0] dest;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOCATE,
    ST_SCAN,
    ST_GRANT,
    ST_DONE
  } state_e;

  // Request store: written at the load index, read at req_q
  req_t store_q [MAX_REQUESTERS];
  req_t wr_entry;
  req_t rd;
  logic store_we;

  state_e            state_q, state_d;
  logic [CntW-1:0]   loaded_q, loaded_d;
  logic [PW-1:0]     npos_q, npos_d;
  logic [CURSOR_W-1:0] rr_cursor_q, rr_cursor_d;
  logic [PW-1:0]     cursor_q, cursor_d;   // cursor as read for this round
  logic [PW-1:0]     base_q, base_d;       // first position of req_q while locating
  logic [PW-1:0]     pos_q, pos_d;         // current flat position while scanning
  logic [PW-1:0]     off_q, off_d;         // positions visited so far
  logic [PW-1:0]     next_q, next_d;       // cursor to store after the round
  logic [ReqW-1:0]   req_q, req_d;
  logic [EvW-1:0]    ev_q, ev_d;
  logic [CntW-1:0]   j_q, j_d;             // requesters visited in the grant walk
  logic [LaneW-1:0]  occ_q, occ_d;
  logic [GW-1:0]     granted_q, granted_d;
  logic              found_q, found_d;

  logic                out_valid_q, out_valid_d;
  logic [GRANT_W-1:0]  out_grant_q, out_grant_d;
  logic [CURSOR_W-1:0] out_cursor_q, out_cursor_d;
  logic                out_found_q, out_found_d;

  // Clamped evaluation count of the incoming beat
  logic [EvCntW-1:0]  in_cnt;
  logic [DEST_W-1:0]  in_dest [DEST_FIELDS];
  logic               in_acc;

  // Per-cycle evaluation of the entry being read
  logic               hit_elig, hit_evald;
  logic [LaneW-1:0]   claims;
  logic               distinct;
  logic               ev_last, req_last, pos_last;
  logic [PW-1:0]      pos_inc;
  logic [ReqW-1:0]    req_inc;
  logic [PW:0]        base_end;

  assign in_i.ready   = (state_q == ST_IDLE);
  assign in_acc       = in_i.valid && in_i.ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.granted_mask   = out_grant_q;
  assign out_o.next_cursor    = out_cursor_q;
  assign out_o.found_eligible = out_found_q;

  always_comb begin
    logic [EVAL_COUNT_W:0] raw;
    raw = {1'b0, in_i.eval_count};
    if (raw == '0) begin
      in_cnt = EvCntW'(1);
    end else if (raw > (EVAL_COUNT_W + 1)'(MAX_EVALS)) begin
      in_cnt = EvCntW'(MAX_EVALS);
    end else begin
      in_cnt = EvCntW'(raw);
    end
  end

  always_comb begin
    in_dest[0] = in_i.lane_dest_a;
    in_dest[1] = in_i.lane_dest_b;
    in_dest[2] = in_i.lane_dest_c;
    in_dest[3] = in_i.lane_dest_d;
    wr_entry.evals = in_cnt;
    wr_entry.elig  = in_i.eligible_bits;
    wr_entry.evald = in_i.evaluated_bits;
    for (int d = 0; d < NDest; d++) begin
      wr_entry.dest[d] = in_dest[d][LaneW-1:0];
    end
  end

  assign store_we = in_acc && (loaded_q < CntW'(MAX_REQUESTERS));

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[loaded_q[ReqW-1:0]] <= wr_entry;
    end
  end

  assign rd = store_q[req_q];

  // Flag lookup for evaluation ev_q; indexes of 4 and up carry no flags
  always_comb begin
    hit_elig  = 1'b0;
    hit_evald = 1'b0;
    for (int k = 0; k < FLAG_W; k++) begin
      if (k < MAX_EVALS && ev_q == EvW'(k)) begin
        hit_elig  = rd.elig[k];
        hit_evald = rd.evald[k];
      end
    end
  end

  // Lane claims of the entry: union plus pairwise-disjoint check
  always_comb begin
    claims   = '0;
    distinct = 1'b1;
    for (int d = 0; d < NDest; d++) begin
      if ((claims & rd.dest[d]) != '0) begin
        distinct = 1'b0;
      end
      claims = claims | rd.dest[d];
    end
  end

  assign ev_last  = ((EvCntW'(ev_q) + EvCntW'(1)) == rd.evals);
  assign req_last = ((CntW'(req_q) + CntW'(1)) == loaded_q);
  assign req_inc  = req_last ? '0 : ReqW'(req_q + ReqW'(1));
  assign pos_last = ((pos_q + PW'(1)) == npos_q);
  assign pos_inc  = pos_last ? '0 : pos_q + PW'(1);
  assign base_end = {1'b0, base_q} + (PW + 1)'(rd.evals);

  always_comb begin
    state_d      = state_q;
    loaded_d     = loaded_q;
    npos_d       = npos_q;
    rr_cursor_d  = rr_cursor_q;
    cursor_d     = cursor_q;
    base_d       = base_q;
    pos_d        = pos_q;
    off_d        = off_q;
    next_d       = next_q;
    req_d        = req_q;
    ev_d         = ev_q;
    j_d          = j_q;
    occ_d        = occ_q;
    granted_d    = granted_q;
    found_d      = found_q;
    out_valid_d  = out_valid_q;
    out_grant_d  = out_grant_q;
    out_cursor_d = out_cursor_q;
    out_found_d  = out_found_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (store_we) begin
            loaded_d = loaded_q + CntW'(1);
            npos_d   = npos_q + PW'(in_cnt);
          end
          if (in_i.last_requester) begin
            // stale cursor reads as 0
            cursor_d  = (PW'(rr_cursor_q) >= npos_d) ? '0 : PW'(rr_cursor_q);
            next_d    = cursor_d;
            base_d    = '0;
            req_d     = '0;
            found_d   = 1'b0;
            granted_d = '0;
            state_d   = ST_LOCATE;
          end
        end
      end
      ST_LOCATE: begin
        if (base_end > {1'b0, cursor_q}) begin
          ev_d    = EvW'(cursor_q - base_q);
          pos_d   = cursor_q;
          off_d   = '0;
          state_d = ST_SCAN;
        end else begin
          base_d = base_end[PW-1:0];
          req_d  = req_inc;
        end
      end
      ST_SCAN: begin
        if (hit_elig) begin
          found_d = 1'b1;
          if (hit_evald) begin
            next_d = pos_inc;
          end
          j_d     = '0;
          occ_d   = '0;
          state_d = ST_GRANT;       // req_q already holds the focus requester
        end else if (off_q + PW'(1) == npos_q) begin
          state_d = ST_DONE;
        end else begin
          off_d = off_q + PW'(1);
          pos_d = pos_inc;
          if (ev_last) begin
            ev_d  = '0;
            req_d = req_inc;
          end else begin
            ev_d = ev_q + EvW'(1);
          end
        end
      end
      ST_GRANT: begin
        if (distinct && claims != '0 && (claims & occ_q) == '0) begin
          granted_d = granted_q | (GW'(1) << req_q);
          occ_d     = occ_q | claims;
        end
        req_d = req_inc;
        j_d   = j_q + CntW'(1);
        if (j_q + CntW'(1) == loaded_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_grant_d  = granted_q[GRANT_W-1:0];
          out_cursor_d = next_q[CURSOR_W-1:0];
          out_found_d  = found_q;
          rr_cursor_d  = next_q[CURSOR_W-1:0];
          loaded_d     = '0;
          npos_d       = '0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      loaded_q     <= '0;
      npos_q       <= '0;
      rr_cursor_q  <= '0;
      out_valid_q  <= 1'b0;
      cursor_q     <= '0;
      base_q       <= '0;
      pos_q        <= '0;
      off_q        <= '0;
      next_q       <= '0;
      req_q        <= '0;
      ev_q         <= '0;
      j_q          <= '0;
      occ_q        <= '0;
      granted_q    <= '0;
      found_q      <= 1'b0;
      out_grant_q  <= '0;
      out_cursor_q <= '0;
      out_found_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      loaded_q     <= loaded_d;
      npos_q       <= npos_d;
      rr_cursor_q  <= rr_cursor_d;
      out_valid_q  <= out_valid_d;
      cursor_q     <= cursor_d;
      base_q       <= base_d;
      pos_q        <= pos_d;
      off_q        <= off_d;
      next_q       <= next_d;
      req_q        <= req_d;
      ev_q         <= ev_d;
      j_q          <= j_d;
      occ_q        <= occ_d;
      granted_q    <= granted_d;
      found_q      <= found_d;
      out_grant_q  <= out_grant_d;
      out_cursor_q <= out_cursor_d;
      out_found_q  <= out_found_d;
    end
  end

  // Checks
  a_loaded_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= CntW'(MAX_REQUESTERS))
    else $error("loaded count beyond store depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> (pos_q < npos_q) && (off_q < npos_q))
    else $error("scan position outside flattened range");

  a_no_found_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_found_q |-> out_grant_q == '0)
    else $error("grant issued without an eligible position");

  a_grant_claims_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_GRANT && granted_q != '0 |-> occ_q != '0)
    else $error("grant recorded with no lanes occupied");

  a_round_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && state_d == ST_IDLE |=> loaded_q == '0 && npos_q == '0 && out_valid_q)
    else $error("round end did not clear load state");

endmodule

// File: dv/lane_conflict_round_robin_selector_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for lane_conflict_round_robin_selector: requester beats in, grant
// beats out, each grant checked against a predictor kept inside this file.
// Depends on lcrr_pkg, the channel interfaces in lcrr_in_if.sv and the selector itself.
module lane_conflict_round_robin_selector_tb
  import lcrr_pkg::*;
();

  // Block configuration, passed to the instance and used by the predictor.
  localparam int REQ_SLOTS  = 8;
  localparam int EVAL_SLOTS = 4;
  localparam int DEST_SLOTS = 4;
  localparam int LANES      = 16;
  localparam int POS_SLOTS  = REQ_SLOTS * EVAL_SLOTS;

  localparam int RESET_CYCLES = 10;
  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int MAX_REPORTS  = 10;
  localparam int SETTLE_CYCLES = 64;
  // Longest correct stretch with no beat on either side: one hold-off plus a round plus a
  // slow receiver window. Taken several times over.
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [EVAL_COUNT_W-1:0]            eval_count;
    logic [FLAG_W-1:0]                  eligible;
    logic [FLAG_W-1:0]                  evaluated;
    logic [DEST_FIELDS-1:0][DEST_W-1:0] dest;
    logic                               last;
  } request_t;

  typedef struct packed {
    logic [GRANT_W-1:0]  granted;
    logic [CURSOR_W-1:0] cursor;
    logic                found;
  } grant_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  lcrr_in_if  req_if ();
  lcrr_out_if grant_if ();

  lane_conflict_round_robin_selector #(
    .MAX_REQUESTERS     (REQ_SLOTS),
    .MAX_EVALS          (EVAL_SLOTS),
    .DESTS_PER_REQUESTER(DEST_SLOTS),
    .LANE_COUNT         (LANES)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (grant_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor: shadow request store, fill count and flat-position cursor.
  // ---------------------------------------------------------------------------------------
  int unsigned                        shadow_loaded = 0;
  logic [CURSOR_W-1:0]                shadow_cursor = '0;
  int unsigned                        shadow_evals [REQ_SLOTS];
  logic [FLAG_W-1:0]                  shadow_elig  [REQ_SLOTS];
  logic [FLAG_W-1:0]                  shadow_done  [REQ_SLOTS];
  logic [DEST_FIELDS-1:0][DEST_W-1:0] shadow_dest  [REQ_SLOTS];

  request_t    pending_requests [$];  // beats waiting for the driver
  grant_t      expected_grants [$];   // grants predicted, not yet seen
  int unsigned queued_reqs   = 0;
  int unsigned accepted_reqs = 0;
  int unsigned mismatches    = 0;

  // One selection round over the requesters loaded so far.
  function automatic grant_t select_round();
    int unsigned      pos_req  [POS_SLOTS];
    int unsigned      pos_eval [POS_SLOTS];
    int unsigned      n, npos, start, next, focus, owner, q, r, k, off, j, d;
    logic [LANES-1:0] occupied, claims;
    logic             distinct, hit;
    grant_t           res;
    n        = shadow_loaded;
    npos     = 0;
    res      = '0;
    occupied = '0;
    hit      = 1'b0;
    // Flatten (requester, evaluation) positions, requester-major.
    for (r = 0; r < n; r++) begin
      for (k = 0; k < shadow_evals[r]; k++) begin
        pos_req[npos]  = r;
        pos_eval[npos] = k;
        npos++;
      end
    end
    // A cursor past the positions of this round reads as zero.
    start = (shadow_cursor < npos) ? shadow_cursor : 0;
    next  = start;
    for (off = 0; off < npos && !hit; off++) begin
      focus = (start + off) % npos;
      owner = pos_req[focus];
      if (shadow_elig[owner][pos_eval[focus]]) begin
        hit = 1'b1;
        if (shadow_done[owner][pos_eval[focus]]) next = (focus + 1) % npos;
        // Grant walk from the focus requester; masks must be disjoint, nonzero and free.
        for (j = 0; j < n; j++) begin
          q        = (owner + j) % n;
          claims   = '0;
          distinct = 1'b1;
          for (d = 0; d < DEST_SLOTS; d++) begin
            if ((claims & shadow_dest[q][d]) != '0) distinct = 1'b0;
            claims |= shadow_dest[q][d];
          end
          if (distinct && claims != '0 && (claims & occupied) == '0) begin
            res.granted[q] = 1'b1;
            occupied      |= claims;
          end
        end
      end
    end
    res.found     = hit;
    res.cursor    = next[CURSOR_W-1:0];
    shadow_cursor = next[CURSOR_W-1:0];
    shadow_loaded = 0;
    return res;
  endfunction

  // Store one accepted requester beat; the last beat of a round runs the selection.
  task automatic accept_request(request_t rq);
    int unsigned cnt;
    if (shadow_loaded < REQ_SLOTS) begin
      cnt = rq.eval_count;
      if (cnt == 0) cnt = 1;
      if (cnt > EVAL_SLOTS) cnt = EVAL_SLOTS;
      shadow_evals[shadow_loaded] = cnt;
      shadow_elig[shadow_loaded]  = rq.eligible;
      shadow_done[shadow_loaded]  = rq.evaluated;
      shadow_dest[shadow_loaded]  = rq.dest;
      shadow_loaded++;
    end
    if (rq.last) expected_grants.insert(expected_grants.size(), select_round());
  endtask

  // ---------------------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps between them.
  // ---------------------------------------------------------------------------------------
  request_t cur_req;
  int       burst_left;
  int       gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid          <= 1'b0;
      req_if.eval_count     <= '0;
      req_if.eligible_bits  <= '0;
      req_if.evaluated_bits <= '0;
      req_if.lane_dest_a    <= '0;
      req_if.lane_dest_b    <= '0;
      req_if.lane_dest_c    <= '0;
      req_if.lane_dest_d    <= '0;
      req_if.last_requester <= 1'b0;
      burst_left            <= 0;
      gap_left              <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        accept_request(cur_req);
        accepted_reqs++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left     <= gap_left - 1;
          req_if.valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          cur_req               = pending_requests.pop_front();
          req_if.eval_count     <= cur_req.eval_count;
          req_if.eligible_bits  <= cur_req.eligible;
          req_if.evaluated_bits <= cur_req.evaluated;
          req_if.lane_dest_a    <= cur_req.dest[0];
          req_if.lane_dest_b    <= cur_req.dest[1];
          req_if.lane_dest_c    <= cur_req.dest[2];
          req_if.lane_dest_d    <= cur_req.dest[3];
          req_if.last_requester <= cur_req.last;
          req_if.valid          <= 1'b1;
          if (burst_left <= 1) begin
            // mostly short bursts, now and then a long one with no idling
            burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Receiver: stall pattern follows bits [8:7] of a free-running cycle counter; a hold-off
  // request from the stimulus forces ready low while a counter loaded from HOLD_CYCLES runs out.
  // ---------------------------------------------------------------------------------------
  int unsigned hold_requests = 0;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned rx_cycle;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grant_if.ready <= 1'b0;
      hold_served    <= 0;
      hold_left      <= 0;
      rx_cycle       <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_requests != hold_served) begin
        hold_served    <= hold_served + 1;
        hold_left      <= HOLD_CYCLES;
        grant_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left      <= hold_left - 1;
        grant_if.ready <= 1'b0;
      end else begin
        case (rx_cycle[8:7])
          2'd0:    grant_if.ready <= 1'b1;
          2'd1:    grant_if.ready <= 1'($urandom_range(0, 1));
          2'd2:    grant_if.ready <= (rx_cycle[2:0] == 3'd0);
          default: grant_if.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: every grant beat against the oldest prediction, field by field.
  // ---------------------------------------------------------------------------------------
  grant_t seen_grant;
  grant_t want_grant;

  always @(posedge clk_i) begin
    if (rst_ni && grant_if.valid && grant_if.ready) begin
      seen_grant.granted = grant_if.granted_mask;
      seen_grant.cursor  = grant_if.next_cursor;
      seen_grant.found   = grant_if.found_eligible;
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: grant beat with none expected: grant=%02h cursor=%0d found=%0b",
                   $time, seen_grant.granted, seen_grant.cursor, seen_grant.found);
      end else begin
        want_grant = expected_grants.pop_front();
        if (seen_grant.granted !== want_grant.granted ||
            seen_grant.cursor !== want_grant.cursor ||
            seen_grant.found !== want_grant.found) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: grant mismatch: expected grant=%02h cursor=%0d found=%0b",
                     $time, want_grant.granted, want_grant.cursor, want_grant.found);
            $display("    got grant=%02h cursor=%0d found=%0b",
                     seen_grant.granted, seen_grant.cursor, seen_grant.found);
          end
        end
      end
    end
  end

  // Watchdog: too long with no beat on either channel.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (grant_if.valid && grant_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------
  function automatic request_t make_request(logic [EVAL_COUNT_W-1:0] cnt,
                                            logic [FLAG_W-1:0] elig, logic [FLAG_W-1:0] done,
                                            logic [DEST_W-1:0] a, logic [DEST_W-1:0] b,
                                            logic [DEST_W-1:0] c, logic [DEST_W-1:0] d,
                                            logic last);
    request_t rq;
    rq.eval_count = cnt;
    rq.eligible   = elig;
    rq.evaluated  = done;
    rq.dest[0]    = a;
    rq.dest[1]    = b;
    rq.dest[2]    = c;
    rq.dest[3]    = d;
    rq.last       = last;
    return rq;
  endfunction

  // Random requester: sparse lane masks so grants and conflicts both happen often.
  function automatic request_t random_request(logic last);
    request_t rq;
    rq.eval_count = 3'($urandom_range(0, 7));
    rq.eligible   = ($urandom_range(0, 3) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
    rq.evaluated  = 4'($urandom_range(0, 15));
    for (int d = 0; d < DEST_FIELDS; d++) begin
      case ($urandom_range(0, 7))
        0, 1, 2: rq.dest[d] = '0;
        3, 4, 5: rq.dest[d] = 16'h0001 << $urandom_range(0, 15);
        6:       rq.dest[d] = 16'($urandom & $urandom);
        default: rq.dest[d] = 16'($urandom);
      endcase
    end
    rq.last = last;
    return rq;
  endfunction

  task automatic queue_request(request_t rq);
    pending_requests.insert(pending_requests.size(), rq);
    queued_reqs++;
  endtask

  // Whole rounds until the beat budget is used; about one round in ten overflows the store.
  task automatic queue_rounds(int unsigned budget);
    int unsigned sent, len, i;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      for (i = 0; i < len; i++) begin
        queue_request(random_request(i == len - 1));
        sent++;
      end
    end
  endtask

  // Sender pause: wait until every queued beat is taken and every grant has come back.
  task automatic wait_drained();
    while (accepted_reqs != queued_reqs || expected_grants.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int i;
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // lone requester, zero evaluation count
    queue_request(make_request(3'd0, 4'h1, 4'h0, 16'h0001, 16'h0, 16'h0, 16'h0, 1'b1));
    // saturated count, eligible and evaluated only in the top evaluation; all lanes taken
    queue_request(make_request(3'd7, 4'h8, 4'h8, 16'hFFFF, 16'h0, 16'h0, 16'h0, 1'b0));
    // overlapping masks within one requester
    queue_request(make_request(3'd4, 4'h0, 4'hF, 16'h0003, 16'h0002, 16'h0, 16'h0, 1'b0));
    // all masks zero
    queue_request(make_request(3'd5, 4'h0, 4'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0));
    // lanes already claimed by the first grant
    queue_request(make_request(3'd6, 4'h0, 4'h0, 16'h00F0, 16'h0F00, 16'hF000, 16'h000F,
                               1'b1));
    // nothing eligible, cursor from the last round is stale here
    queue_request(make_request(3'd3, 4'h0, 4'hF, 16'h1234, 16'h0, 16'h0, 16'h0, 1'b0));
    queue_request(make_request(3'd1, 4'h0, 4'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 1'b1));
    // evaluated hit in the middle pushes the cursor to 7
    queue_request(make_request(3'd4, 4'h0, 4'h0, 16'h00FF, 16'h0, 16'h0, 16'h0, 1'b0));
    queue_request(make_request(3'd4, 4'h4, 4'h4, 16'hFF00, 16'h0, 16'h0, 16'h0, 1'b0));
    queue_request(make_request(3'd4, 4'h0, 4'h0, 16'h0F0F, 16'h0, 16'h0, 16'h0, 1'b1));
    // two positions only: cursor 7 reads as zero
    queue_request(make_request(3'd2, 4'h2, 4'h0, 16'h0, 16'h0, 16'h0, 16'h0001, 1'b1));
    // ten beats in one round: the last two are dropped, the tenth still triggers
    for (i = 0; i < 10; i++)
      queue_request(make_request(3'(7 - i % 8), 4'hF, 4'(i),
                                 (i < 8) ? 16'h0001 << (2 * i) : 16'hFFFF,
                                 (i < 8) ? 16'h0002 << (2 * i) : 16'hFFFF,
                                 16'h0, 16'h0, i == 9));
    wait_drained();

    // random rounds; the receiver holds off while the sender keeps offering beats
    queue_rounds(320);
    hold_requests++;
    wait_drained();
    queue_rounds(300);
    wait_drained();
    queue_rounds(310);
    hold_requests++;
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_grants.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: lane_conflict_round_robin_selector.f
design/lcrr_pkg.sv
design/lcrr_in_if.sv
design/lane_conflict_round_robin_selector.sv
dv/lane_conflict_round_robin_selector_tb.sv
